// ----- design/deq_pkg.sv -----
// shared constants, codes and index helpers for the double-ended queue
// no dependencies; imported by the channel interfaces and all modules

package deq_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;
  localparam int KIND_W = 3;
  localparam int STAT_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_QUERY      = 3'd4
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_t;

  // next index, wrapping at the store size
  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] res;
    if (idx == IDX_W'(DEPTH - 1)) res = '0;
    else res = idx + IDX_W'(1);
    return res;
  endfunction

  // previous index, wrapping at the store size
  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] res;
    if (idx == '0) res = IDX_W'(DEPTH - 1);
    else res = idx - IDX_W'(1);
    return res;
  endfunction

  // base plus an offset of at most DEPTH, modulo the store size
  function automatic logic [IDX_W-1:0] idx_add(input logic [IDX_W-1:0] base,
                                               input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(DEPTH)) sum = sum - (CNT_W+1)'(DEPTH);
    return sum[IDX_W-1:0];
  endfunction

endpackage

// ----- design/deq_in_if.sv -----
// request channel of the double-ended queue: valid/ready plus operation fields
// depends on deq_pkg

interface deq_in_if import deq_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

// ----- design/deq_out_if.sv -----
// result channel of the double-ended queue: valid/ready plus result fields
// depends on deq_pkg

interface deq_out_if import deq_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [WORD_W-1:0] popped_value;
  logic signed [WORD_W-1:0] front_value;
  logic signed [WORD_W-1:0] back_value;
  logic [CNT_W-1:0]         fill_count;

  modport source (output valid, output status, output popped_value,
                  output front_value, output back_value, output fill_count,
                  input ready);
  modport sink   (input valid, input status, input popped_value,
                  input front_value, input back_value, input fill_count,
                  output ready);
endinterface

// ----- design/double_ended_queue.sv -----
// bounded double-ended queue of signed 32-bit words, top level
// depends on deq_pkg, deq_in_if and deq_out_if

// A bounded deque of DEPTH signed words (DEPTH = 16) held in a circular
// single-port-write, registered-read store addressed by a head index and a
// fill count. Each request on in_ch asks for push front, push back, pop
// front, pop back or a query (unused kind codes act as a query), and gives
// exactly one result on out_ch: status, popped word, front and back words
// after the operation (all ones when empty) and the fill count. Pushes,
// queries, refused operations and pops that leave the queue empty give
// their result the cycle after acceptance. A pop that leaves one or more
// words goes through ST_READ first, because the new front or back word
// must be fetched through the store's registered read port. A new request is
// taken in the same cycle the previous result is taken, so with a ready
// sink the block sustains one request per cycle, except that such a pop
// holds off the next request during ST_READ. There is no clearing pass
// after reset; the store is only ever read at occupied entries.

module double_ended_queue import deq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  deq_in_if.sink    in_ch,
  deq_out_if.source out_ch
);

  // control state
  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] occ_r, occ_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             rd_front_r, rd_front_nxt;

  // cached end words and result payload
  logic [WORD_W-1:0] front_r, front_nxt;
  logic [WORD_W-1:0] back_r, back_nxt;
  logic [WORD_W-1:0] popped_r, popped_nxt;
  status_t           status_r, status_nxt;

  // word store
  logic [WORD_W-1:0] mem [DEPTH];
  logic              wr_en, rd_en;
  logic [IDX_W-1:0]  wr_addr, rd_addr;
  logic [WORD_W-1:0] wr_data;
  logic [WORD_W-1:0] rd_data_r;

  logic in_ready;
  logic in_fire;

  // one request at a time; the next one may enter as the result leaves
  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire  = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  // front and back come straight from the cached end words, which cannot
  // change while a result is pending
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = status_r;
  assign out_ch.popped_value = popped_r;
  assign out_ch.front_value  = (occ_r == '0) ? '1 : front_r;
  assign out_ch.back_value   = (occ_r == '0) ? '1 : back_r;
  assign out_ch.fill_count   = occ_r;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    occ_nxt       = occ_r;
    out_valid_nxt = out_valid_r;
    rd_front_nxt  = rd_front_r;
    front_nxt     = front_r;
    back_nxt      = back_r;
    popped_nxt    = popped_r;
    status_nxt    = status_r;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = in_ch.value;
    rd_en         = 1'b0;
    rd_addr       = '0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          popped_nxt    = '0;
          status_nxt    = STAT_DONE;
          out_valid_nxt = 1'b1;
          case (in_ch.kind)
            KIND_PUSH_FRONT: begin
              if (occ_r == CNT_W'(DEPTH)) begin
                status_nxt = STAT_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = idx_dec(head_r);
                head_nxt  = idx_dec(head_r);
                occ_nxt   = occ_r + CNT_W'(1);
                front_nxt = in_ch.value;
                if (occ_r == '0) back_nxt = in_ch.value;
              end
            end
            KIND_PUSH_BACK: begin
              if (occ_r == CNT_W'(DEPTH)) begin
                status_nxt = STAT_FULL;
              end else begin
                wr_en    = 1'b1;
                wr_addr  = idx_add(head_r, occ_r);
                occ_nxt  = occ_r + CNT_W'(1);
                back_nxt = in_ch.value;
                if (occ_r == '0) front_nxt = in_ch.value;
              end
            end
            KIND_POP_FRONT: begin
              if (occ_r == '0) begin
                status_nxt = STAT_EMPTY;
              end else begin
                popped_nxt = front_r;
                head_nxt   = idx_inc(head_r);
                occ_nxt    = occ_r - CNT_W'(1);
                // words remain: fetch the new front word
                if (occ_r > CNT_W'(1)) begin
                  rd_en         = 1'b1;
                  rd_addr       = idx_inc(head_r);
                  rd_front_nxt  = 1'b1;
                  out_valid_nxt = 1'b0;
                  state_nxt     = ST_READ;
                end
              end
            end
            KIND_POP_BACK: begin
              if (occ_r == '0) begin
                status_nxt = STAT_EMPTY;
              end else begin
                popped_nxt = back_r;
                occ_nxt    = occ_r - CNT_W'(1);
                // words remain: fetch the new back word
                if (occ_r > CNT_W'(1)) begin
                  rd_en         = 1'b1;
                  rd_addr       = idx_add(head_r, occ_r - CNT_W'(2));
                  rd_front_nxt  = 1'b0;
                  out_valid_nxt = 1'b0;
                  state_nxt     = ST_READ;
                end
              end
            end
            default: begin
              // query and unused codes leave the state alone
            end
          endcase
        end
      end
      ST_READ: begin
        if (rd_front_r) front_nxt = rd_data_r;
        else back_nxt = rd_data_r;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // store: one write port, one registered read port, never both in a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
      rd_front_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
      rd_front_r  <= rd_front_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    front_r  <= front_nxt;
    back_r   <= back_nxt;
    popped_r <= popped_nxt;
    status_r <= status_nxt;
  end

endmodule

// ----- design/deq_checker.sv -----
// port-level checks for the double-ended queue, bound to the top level
// depends on deq_pkg and double_ended_queue

module deq_checker import deq_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [STAT_W-1:0]        out_status,
  input logic signed [WORD_W-1:0] out_popped_value,
  input logic signed [WORD_W-1:0] out_front_value,
  input logic signed [WORD_W-1:0] out_back_value,
  input logic [CNT_W-1:0]         out_fill_count
);

  // an empty queue reports all ones at both ends
  a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fill_count == '0 |-> out_front_value == '1 && out_back_value == '1)
    else $error("empty queue does not report all ones at front and back");

  // a single word is both the front and the back
  a_single_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fill_count == CNT_W'(1) |-> out_front_value == out_back_value)
    else $error("single word queue reports different front and back");

  // refused operations carry the boundary fill and no popped word
  a_refusal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_DONE |->
      out_popped_value == '0 &&
      ((out_status == STAT_FULL && out_fill_count == CNT_W'(DEPTH)) ||
       (out_status == STAT_EMPTY && out_fill_count == '0)))
    else $error("refused request with wrong fill or popped word");

  // fill never goes past the store size
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_fill_count <= CNT_W'(DEPTH))
    else $error("fill count beyond store size");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_fill_count) &&
      $stable(out_front_value) && $stable(out_back_value))
    else $error("stalled result changed");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_status       (out_ch.status),
  .out_popped_value (out_ch.popped_value),
  .out_front_value  (out_ch.front_value),
  .out_back_value   (out_ch.back_value),
  .out_fill_count   (out_ch.fill_count)
);
